// ===== rtl/mfbld_pkg.sv =====
// Shared constants, codes and control types of the monochrome frame buffer line drawer.
package mfbld_pkg;

   localparam int FRAME_WIDTH  = 200;
   localparam int FRAME_HEIGHT = 200;
   localparam int ROW_BYTES    = (FRAME_WIDTH + 7) / 8;
   localparam int STORE_BYTES  = ROW_BYTES * FRAME_HEIGHT;
   localparam int ADDR_W       = $clog2(STORE_BYTES);

   typedef enum logic [2:0] {
      CMD_FILL  = 3'd0,
      CMD_PIXEL = 3'd1,
      CMD_HLINE = 3'd2,
      CMD_VLINE = 3'd3,
      CMD_READ  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_FILL,
      ST_RD,
      ST_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic sweep_write;
      logic sweep_fill;
      logic rmw_write;
      logic capture;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    in_frame;
      logic    len_zero;
      logic    last_elem;
      logic    last_sweep;
   } dp_status_type;

endpackage

// ===== rtl/mono_frame_buffer_line_draw.sv =====
// Top level of the 1-bit-per-pixel frame buffer with point, line, fill and read commands.
// Usage:
//   Request: drive req_* and raise start; the request is taken at a rising edge
//   with start high and busy low. busy stays high until the response is given.
//   Response: rsp_strobe is high for exactly one cycle with rsp_status,
//   rsp_clipped and rsp_read_data; the receiver cannot stall it.
// Sequencing, from the accepting edge: the request is registered and decoded;
//   a rejected point, zero-length line or unused command goes straight to the response
//   pixel and read: one store byte is read, then written (pixel) or captured (read)
//   hline and vline: each touched byte (one per row for vline) is read, then written
//   fill: one store byte written per cycle over all 5000 store bytes
//   Each touched byte is read and then written on the single store
//   read-modify-write path; busy drops in the cycle after the strobe.
// Reset: synchronous, active high. After reset the store is swept to all
//   white, one byte per cycle over all 5000 bytes, with busy high, before
//   the first request is taken.
module mono_frame_buffer_line_draw (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [7:0] req_pos_x,
   input  logic [7:0] req_pos_y,
   input  logic [7:0] req_run_length,
   input  logic       req_ink,
   input  logic [7:0] req_fill_byte,
   output logic       rsp_strobe,
   output logic       rsp_status,
   output logic       rsp_clipped,
   output logic [7:0] rsp_read_data
);

   mfbld_pkg::dp_cmd_type    ctl;
   mfbld_pkg::dp_status_type stat;

   mfbld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .ctl        (ctl),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mfbld_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .req_run_length (req_run_length),
      .req_ink        (req_ink),
      .req_fill_byte  (req_fill_byte),
      .ctl            (ctl),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_clipped    (rsp_clipped),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

// ===== rtl/mfbld_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mfbld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mfbld_datapath.sv =====
// Datapath: request registers, address and mask generation, frame store and result registers.
module mfbld_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [2:0]               req_command,
   input  logic [7:0]               req_pos_x,
   input  logic [7:0]               req_pos_y,
   input  logic [7:0]               req_run_length,
   input  logic                     req_ink,
   input  logic [7:0]               req_fill_byte,
   input  mfbld_pkg::dp_cmd_type    ctl,
   output mfbld_pkg::dp_status_type stat,
   output logic                     rsp_status,
   output logic                     rsp_clipped,
   output logic [7:0]               rsp_read_data
);

   localparam logic [8:0] W9 = 9'(mfbld_pkg::FRAME_WIDTH);
   localparam logic [8:0] H9 = 9'(mfbld_pkg::FRAME_HEIGHT);
   localparam logic [mfbld_pkg::ADDR_W-1:0] ROW_STEP = mfbld_pkg::ADDR_W'(mfbld_pkg::ROW_BYTES);
   localparam logic [mfbld_pkg::ADDR_W-1:0] LAST_ADDR =
      mfbld_pkg::ADDR_W'(mfbld_pkg::STORE_BYTES - 1);

   mfbld_pkg::cmd_type              cmd_ff, cmd_in;
   logic [7:0]                      x_ff;
   logic [8:0]                      xhi_ff, xhi_in;
   logic [8:0]                      yhi_ff, yhi_in;
   logic [7:0]                      row_ff;
   logic [4:0]                      byte_ff;
   logic [mfbld_pkg::ADDR_W-1:0]    addr_ff, addr_in;
   logic                            ink_ff;
   logic [7:0]                      fill_ff;
   logic                            inside_ff, inside_in;
   logic                            len_zero_ff;
   logic                            status_ff, status_in;
   logic                            clipped_ff, clipped_in;
   logic [7:0]                      rdata_ff;

   logic [8:0]                      x9, y9, len9, xsum, ysum, xhi_m1, px;
   logic                            is_h, is_v, is_pt;
   logic [mfbld_pkg::ADDR_W-1:0]    row_base;
   logic [7:0]                      mask, ram_rd, rmw_data, wr_data;

   // Request decode at accept
   always_comb begin
      cmd_in     = mfbld_pkg::cmd_type'(req_command);
      x9         = {1'b0, req_pos_x};
      y9         = {1'b0, req_pos_y};
      len9       = {1'b0, req_run_length};
      xsum       = x9 + len9;
      ysum       = y9 + len9;
      is_h       = (cmd_in == mfbld_pkg::CMD_HLINE);
      is_v       = (cmd_in == mfbld_pkg::CMD_VLINE);
      is_pt      = (cmd_in == mfbld_pkg::CMD_PIXEL) || (cmd_in == mfbld_pkg::CMD_READ) ||
                   is_h || is_v;
      inside_in  = (x9 < W9) && (y9 < H9);
      xhi_in     = is_h ? ((xsum > W9) ? W9 : xsum) : (x9 + 9'd1);
      yhi_in     = is_v ? ((ysum > H9) ? H9 : ysum) : (y9 + 9'd1);
      status_in  = is_pt && !inside_in;
      clipped_in = inside_in && ((is_h && (xsum > W9)) || (is_v && (ysum > H9)));
      row_base   = mfbld_pkg::ADDR_W'(32'(req_pos_y) * 32'(mfbld_pkg::ROW_BYTES));
      addr_in    = (cmd_in == mfbld_pkg::CMD_FILL) ? '0 :
                   row_base + mfbld_pkg::ADDR_W'(req_pos_x[7:3]);
   end

   // Bit mask of the current byte: pixels in [x_ff, xhi_ff)
   always_comb begin
      mask = '0;
      for (int j = 0; j < 8; j++) begin
         px = {1'b0, byte_ff, 3'(j)};
         mask[7-j] = (px >= {1'b0, x_ff}) && (px < xhi_ff);
      end
   end

   assign xhi_m1   = xhi_ff - 9'd1;
   assign rmw_data = ink_ff ? (ram_rd & ~mask) : (ram_rd | mask);
   assign wr_data  = ctl.sweep_write ? (ctl.sweep_fill ? fill_ff : 8'hFF) : rmw_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= '0;
      end else if (ctl.load) begin
         addr_ff <= addr_in;
      end else if (ctl.sweep_write) begin
         addr_ff <= addr_ff + mfbld_pkg::ADDR_W'(1);
      end else if (ctl.rmw_write) begin
         addr_ff <= (cmd_ff == mfbld_pkg::CMD_HLINE) ? addr_ff + mfbld_pkg::ADDR_W'(1) :
                                                       addr_ff + ROW_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff      <= cmd_in;
         x_ff        <= req_pos_x;
         xhi_ff      <= xhi_in;
         yhi_ff      <= yhi_in;
         row_ff      <= req_pos_y;
         byte_ff     <= req_pos_x[7:3];
         ink_ff      <= req_ink;
         fill_ff     <= req_fill_byte;
         inside_ff   <= inside_in;
         len_zero_ff <= (req_run_length == 8'd0);
         status_ff   <= status_in;
         clipped_ff  <= clipped_in;
         rdata_ff    <= 8'd0;
      end else begin
         if (ctl.rmw_write) begin
            if (cmd_ff == mfbld_pkg::CMD_HLINE) begin
               byte_ff <= byte_ff + 5'd1;
            end else begin
               row_ff <= row_ff + 8'd1;
            end
         end
         if (ctl.capture) begin
            rdata_ff <= ram_rd;
         end
      end
   end

   mfbld_ram #(
      .WIDTH (8),
      .DEPTH (mfbld_pkg::STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ctl.sweep_write | ctl.rmw_write),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (addr_ff),
      .rd_data (ram_rd)
   );

   always_comb begin
      stat.cmd        = cmd_ff;
      stat.in_frame   = inside_ff;
      stat.len_zero   = len_zero_ff;
      stat.last_elem  = (byte_ff == xhi_m1[7:3]) && (({1'b0, row_ff} + 9'd1) == yhi_ff);
      stat.last_sweep = (addr_ff == LAST_ADDR);
   end

   assign rsp_status    = status_ff;
   assign rsp_clipped   = clipped_ff;
   assign rsp_read_data = rdata_ff;

endmodule

// ===== rtl/mfbld_ctrl.sv =====
// Controller state machine: clearing pass, command sequencing and response strobe.
module mfbld_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  mfbld_pkg::dp_status_type stat,
   output mfbld_pkg::dp_cmd_type    ctl,
   output logic                     busy,
   output logic                     rsp_strobe
);

   mfbld_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfbld_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfbld_pkg::ST_CLEAR: begin
            if (stat.last_sweep) state_in = mfbld_pkg::ST_IDLE;
         end
         mfbld_pkg::ST_IDLE: begin
            if (start) state_in = mfbld_pkg::ST_DECODE;
         end
         mfbld_pkg::ST_DECODE: begin
            unique case (stat.cmd) inside
               mfbld_pkg::CMD_FILL: begin
                  state_in = mfbld_pkg::ST_FILL;
               end
               mfbld_pkg::CMD_PIXEL, mfbld_pkg::CMD_READ: begin
                  state_in = stat.in_frame ? mfbld_pkg::ST_RD : mfbld_pkg::ST_DONE;
               end
               mfbld_pkg::CMD_HLINE, mfbld_pkg::CMD_VLINE: begin
                  state_in = (stat.in_frame && !stat.len_zero) ? mfbld_pkg::ST_RD :
                                                                 mfbld_pkg::ST_DONE;
               end
               default: begin
                  state_in = mfbld_pkg::ST_DONE;
               end
            endcase
         end
         mfbld_pkg::ST_FILL: begin
            if (stat.last_sweep) state_in = mfbld_pkg::ST_DONE;
         end
         mfbld_pkg::ST_RD: begin
            state_in = mfbld_pkg::ST_WR;
         end
         mfbld_pkg::ST_WR: begin
            state_in = ((stat.cmd == mfbld_pkg::CMD_READ) || stat.last_elem) ?
                       mfbld_pkg::ST_DONE : mfbld_pkg::ST_RD;
         end
         mfbld_pkg::ST_DONE: begin
            state_in = mfbld_pkg::ST_IDLE;
         end
         default: begin
            state_in = mfbld_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      ctl        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         mfbld_pkg::ST_CLEAR: begin
            ctl.sweep_write = 1'b1;
         end
         mfbld_pkg::ST_IDLE: begin
            busy     = 1'b0;
            ctl.load = start;
         end
         mfbld_pkg::ST_FILL: begin
            ctl.sweep_write = 1'b1;
            ctl.sweep_fill  = 1'b1;
         end
         mfbld_pkg::ST_WR: begin
            if (stat.cmd == mfbld_pkg::CMD_READ) begin
               ctl.capture = 1'b1;
            end else begin
               ctl.rmw_write = 1'b1;
            end
         end
         mfbld_pkg::ST_DONE: begin
            rsp_strobe = 1'b1;
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held for more than one cycle");

   a_accept_decodes: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == mfbld_pkg::ST_DECODE))
      else $error("accepted request not decoded");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mfbld_pkg::ST_WR) |-> ($past(state_ff) == mfbld_pkg::ST_RD))
      else $error("modify-write without preceding store read");

   a_no_mixed_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.sweep_write && (ctl.rmw_write || ctl.load)))
      else $error("sweep write overlaps another datapath command");
`endif

endmodule

// ===== tb/tb_mono_frame_buffer_line_draw.sv =====
// Self-checking testbench for the 1bpp frame buffer: directed and random draw/read requests.
`timescale 1ns / 100ps

module tb_mono_frame_buffer_line_draw;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam logic       INK_WHITE        = 1'b0;
   localparam logic       INK_BLACK        = 1'b1;
   localparam int         STALL_LIMIT      = 20000;
   localparam int         N_RANDOM         = 900;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [7:0] run_length;
      logic       ink;
      logic [7:0] fill_byte;
      logic [6:0] gap_pct;
      logic       drain;
   } draw_req_type;

   typedef struct packed {
      logic       status;
      logic       clipped;
      logic [7:0] read_data;
   } draw_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_command = '0;
   logic [7:0] req_pos_x = '0;
   logic [7:0] req_pos_y = '0;
   logic [7:0] req_run_length = '0;
   logic       req_ink = 1'b0;
   logic [7:0] req_fill_byte = '0;
   logic       rsp_strobe;
   logic       rsp_status;
   logic       rsp_clipped;
   logic [7:0] rsp_read_data;

   draw_req_type pending_q[$];
   draw_rsp_type expected_q[$];
   logic [7:0]   shadow_fb[mfbld_pkg::STORE_BYTES];

   draw_req_type req_now;
   bit           have_req = 1'b0;
   bit           draining = 1'b0;
   logic [6:0]   phase_gap = 7'd16;
   bit           next_drain = 1'b0;
   int           last_x = 0;
   int           last_y = 0;

   int n_total = 0;
   int n_taken = 0;
   int n_checked = 0;
   int n_errors = 0;
   int n_rejected = 0;
   int n_clipped = 0;
   int n_cmd[8];
   int stall_cycles = 0;

   mono_frame_buffer_line_draw DUT (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_run_length(req_run_length),
      .req_ink       (req_ink),
      .req_fill_byte (req_fill_byte),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_clipped   (rsp_clipped),
      .rsp_read_data (rsp_read_data)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void plot_pixel(int x, int y, logic ink);
      int         idx;
      logic [7:0] mask;
      idx = y * mfbld_pkg::ROW_BYTES + x / 8;
      mask = 8'h80 >> (x % 8);
      if (ink == INK_BLACK)
         shadow_fb[idx] = shadow_fb[idx] & ~mask;
      else
         shadow_fb[idx] = shadow_fb[idx] | mask;
   endfunction

   // Applies one accepted request to the shadow frame and queues its response.
   function automatic void model_request(draw_req_type r);
      draw_rsp_type e;
      int           px;
      int           py;
      int           x;
      int           y;
      int           len;
      bit           in_frame;
      e = '0;
      x = int'(r.pos_x);
      y = int'(r.pos_y);
      len = int'(r.run_length);
      in_frame = (x < mfbld_pkg::FRAME_WIDTH) && (y < mfbld_pkg::FRAME_HEIGHT);
      case (r.command) inside
         mfbld_pkg::CMD_FILL: begin
            for (int i = 0; i < mfbld_pkg::STORE_BYTES; i++)
               shadow_fb[i] = r.fill_byte;
         end
         mfbld_pkg::CMD_PIXEL: begin
            if (in_frame)
               plot_pixel(x, y, r.ink);
            else
               e.status = 1'b1;
         end
         mfbld_pkg::CMD_HLINE, mfbld_pkg::CMD_VLINE: begin
            if (!in_frame) begin
               e.status = 1'b1;
            end else begin
               for (int i = 0; i < len; i++) begin
                  px = (r.command == mfbld_pkg::CMD_HLINE) ? x + i : x;
                  py = (r.command == mfbld_pkg::CMD_VLINE) ? y + i : y;
                  if (px < mfbld_pkg::FRAME_WIDTH && py < mfbld_pkg::FRAME_HEIGHT)
                     plot_pixel(px, py, r.ink);
                  else
                     e.clipped = 1'b1;
               end
            end
         end
         mfbld_pkg::CMD_READ: begin
            if (in_frame)
               e.read_data = shadow_fb[y * mfbld_pkg::ROW_BYTES + x / 8];
            else
               e.status = 1'b1;
         end
         default: ;
      endcase
      n_cmd[r.command]++;
      if (e.status)
         n_rejected++;
      if (e.clipped)
         n_clipped++;
      n_taken++;
      expected_q.push_back(e);
   endfunction

   function automatic void add_request(logic [2:0] cmd, int x, int y, int len, logic ink,
                                       logic [7:0] fill);
      draw_req_type r;
      r.command = cmd;
      r.pos_x = 8'(x);
      r.pos_y = 8'(y);
      r.run_length = 8'(len);
      r.ink = ink;
      r.fill_byte = fill;
      r.gap_pct = phase_gap;
      r.drain = next_drain;
      next_drain = 1'b0;
      pending_q.push_back(r);
      n_total++;
   endfunction

   function automatic int pick_coord(int limit);
      if ($urandom_range(99) < 10)
         return $urandom_range(255);
      return $urandom_range(limit - 1);
   endfunction

   function automatic void add_random_request();
      int         sel;
      int         x;
      int         y;
      int         len;
      logic [2:0] cmd;
      sel = $urandom_range(99);
      x = pick_coord(mfbld_pkg::FRAME_WIDTH);
      y = pick_coord(mfbld_pkg::FRAME_HEIGHT);
      len = $urandom_range(255);
      if (sel < 1) begin
         cmd = mfbld_pkg::CMD_FILL;
      end else if (sel < 20) begin
         cmd = mfbld_pkg::CMD_PIXEL;
      end else if (sel < 38) begin
         cmd = mfbld_pkg::CMD_HLINE;
         if ($urandom_range(99) < 85)
            len = $urandom_range(32);
      end else if (sel < 53) begin
         cmd = mfbld_pkg::CMD_VLINE;
         if ($urandom_range(99) < 88)
            len = $urandom_range(24);
      end else if (sel < 97) begin
         cmd = mfbld_pkg::CMD_READ;
         // half of the reads land next to the latest drawn point
         if ($urandom_range(1) == 0) begin
            x = last_x + $urandom_range(15);
            y = last_y + $urandom_range(3);
         end
      end else begin
         cmd = 3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST));
      end
      if (cmd == mfbld_pkg::CMD_PIXEL || cmd == mfbld_pkg::CMD_HLINE ||
          cmd == mfbld_pkg::CMD_VLINE) begin
         last_x = x;
         last_y = y;
      end
      add_request(cmd, x, y, len, 1'($urandom_range(1)), 8'($urandom_range(255)));
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            model_request(req_now);
            have_req = 1'b0;
         end
         if (!have_req && pending_q.size() != 0) begin
            req_now = pending_q.pop_front();
            have_req = 1'b1;
            draining = req_now.drain;
         end
         if (draining && !start && !busy)
            draining = 1'b0;
         start <= have_req && !draining && ($urandom_range(99) >= req_now.gap_pct);
         req_command <= req_now.command;
         req_pos_x <= req_now.pos_x;
         req_pos_y <= req_now.pos_y;
         req_run_length <= req_now.run_length;
         req_ink <= req_now.ink;
         req_fill_byte <= req_now.fill_byte;
      end
   end

   // response monitor
   always @(posedge clock) begin
      draw_rsp_type e;
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected response status %0d clipped %0d read_data %02h",
                     $time, rsp_status, rsp_clipped, rsp_read_data);
            n_errors++;
         end else begin
            e = expected_q.pop_front();
            n_checked++;
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               n_errors++;
            end
            if (rsp_clipped !== e.clipped) begin
               $display("%0t: clipped expected %0d actual %0d", $time, e.clipped,
                        rsp_clipped);
               n_errors++;
            end
            if (rsp_read_data !== e.read_data) begin
               $display("%0t: read_data expected %02h actual %02h", $time, e.read_data,
                        rsp_read_data);
               n_errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("mono_frame_buffer_line_draw regression: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < mfbld_pkg::STORE_BYTES; i++)
         shadow_fb[i] = 8'hFF;
      for (int i = 0; i < 8; i++)
         n_cmd[i] = 0;

      add_request(mfbld_pkg::CMD_READ, 0, 0, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_PIXEL, 0, 0, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 0, 0, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_PIXEL, 199, 199, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 199, 199, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_PIXEL, 200, 5, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 3, 200, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_HLINE, 255, 255, 10, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_VLINE, 0, 200, 1, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_HLINE, 10, 20, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_VLINE, 10, 20, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_HLINE, 190, 20, 255, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 192, 20, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_VLINE, 5, 190, 20, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 5, 199, 0, INK_WHITE, 8'h00);
      add_request(CMD_UNUSED_FIRST, 1, 1, 1, INK_BLACK, 8'h55);
      add_request(CMD_UNUSED_LAST, 2, 2, 2, INK_BLACK, 8'hAA);
      add_request(mfbld_pkg::CMD_FILL, 0, 0, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_HLINE, 0, 7, 200, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 197, 7, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_VLINE, 199, 0, 200, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 199, 100, 0, INK_WHITE, 8'h00);
      add_request(mfbld_pkg::CMD_FILL, 77, 33, 9, INK_BLACK, 8'hFF);
      add_request(mfbld_pkg::CMD_PIXEL, 100, 100, 0, INK_BLACK, 8'h00);
      add_request(mfbld_pkg::CMD_READ, 100, 100, 0, INK_WHITE, 8'h00);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM / 3) begin
            phase_gap = 7'd63;
            next_drain = 1'b1;
         end else if (i == 2 * N_RANDOM / 3) begin
            phase_gap = 7'd0;
            next_drain = 1'b1;
         end else if (i == N_RANDOM / 6) begin
            next_drain = 1'b1;
         end
         add_random_request();
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (n_taken != n_total)
         @(posedge clock);
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (50) @(posedge clock);

      $display("Ran %0d requests (%0d responses checked): fill %0d, pixel %0d, hline %0d,",
               n_taken, n_checked, n_cmd[mfbld_pkg::CMD_FILL], n_cmd[mfbld_pkg::CMD_PIXEL],
               n_cmd[mfbld_pkg::CMD_HLINE]);
      $display("  vline %0d, read %0d, unused %0d; %0d out of bounds, %0d clipped lines",
               n_cmd[mfbld_pkg::CMD_VLINE], n_cmd[mfbld_pkg::CMD_READ],
               n_taken - n_cmd[mfbld_pkg::CMD_FILL] - n_cmd[mfbld_pkg::CMD_PIXEL] -
               n_cmd[mfbld_pkg::CMD_HLINE] - n_cmd[mfbld_pkg::CMD_VLINE] -
               n_cmd[mfbld_pkg::CMD_READ], n_rejected, n_clipped);
      if (n_errors == 0)
         $display("mono_frame_buffer_line_draw regression: pass");
      else
         $display("mono_frame_buffer_line_draw regression: fail");
      $finish;
   end

endmodule
